>>> hw/rtl/bsfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bsfc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_DCMP,
        ST_RAD,
        ST_SQRT,
        ST_XFORM,
        ST_VSAT,
        ST_DKEY,
        ST_R2,
        ST_EDGE,
        ST_TEST,
        ST_OUT
    } state_t;

    localparam logic [2:0] CAUSE_NONE   = 3'd0;
    localparam logic [2:0] CAUSE_DIST   = 3'd1;
    localparam logic [2:0] CAUSE_LEFT   = 3'd2;
    localparam logic [2:0] CAUSE_RIGHT  = 3'd3;
    localparam logic [2:0] CAUSE_TOP    = 3'd4;
    localparam logic [2:0] CAUSE_BOTTOM = 3'd5;

    localparam logic [31:0] ROOT2_Q30 = 32'd1518500250;
    localparam logic [31:0] TAN_RESET = 32'd26145;

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_MESH = 1'b1;

    localparam logic [0:0] REG_TAN  = 1'b0;
    localparam logic [0:0] REG_DIST = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic       capture;
        logic       step_clr;
        logic       step_inc;
        state_t     phase;
        logic       out_set;
        logic       dist_rej;
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic       dist_over;
        logic       step_last;
        logic       sqrt_done;
    } stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/bsfc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bsfc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           op,
    output logic                in_ready,
    input  wire logic           out_valid,
    input  wire logic           out_ready,
    input  wire logic [63:0]    dist_reject_sq,
    input  wire bsfc_pkg::stat_t stat,
    output bsfc_pkg::cmd_t      cmd
);

    bsfc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bsfc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsfc_pkg::ST_IDLE:
                if (in_valid && in_ready && op == bsfc_pkg::OP_MESH)
                    state_next = (dist_reject_sq != 64'd0) ? bsfc_pkg::ST_DIST
                                                          : bsfc_pkg::ST_RAD;
            bsfc_pkg::ST_DIST:
                if (stat.step_last) state_next = bsfc_pkg::ST_DCMP;
            bsfc_pkg::ST_DCMP:
                state_next = stat.dist_over ? bsfc_pkg::ST_OUT : bsfc_pkg::ST_RAD;
            bsfc_pkg::ST_RAD:
                if (stat.step_last) state_next = bsfc_pkg::ST_SQRT;
            bsfc_pkg::ST_SQRT:
                if (stat.sqrt_done) state_next = bsfc_pkg::ST_XFORM;
            bsfc_pkg::ST_XFORM:
                if (stat.step_last) state_next = bsfc_pkg::ST_VSAT;
            bsfc_pkg::ST_VSAT:
                if (stat.step_last) state_next = bsfc_pkg::ST_DKEY;
            bsfc_pkg::ST_DKEY:
                if (stat.step_last) state_next = bsfc_pkg::ST_R2;
            bsfc_pkg::ST_R2:
                state_next = bsfc_pkg::ST_EDGE;
            bsfc_pkg::ST_EDGE:
                state_next = bsfc_pkg::ST_TEST;
            bsfc_pkg::ST_TEST:
                state_next = bsfc_pkg::ST_OUT;
            bsfc_pkg::ST_OUT:
                if (!out_valid || out_ready) state_next = bsfc_pkg::ST_IDLE;
            default:
                state_next = bsfc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.phase = state_reg;
        in_ready = 1'b0;
        case (state_reg)
            bsfc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.capture = in_valid;
                cmd.step_clr = 1'b1;
            end
            bsfc_pkg::ST_DIST, bsfc_pkg::ST_RAD, bsfc_pkg::ST_XFORM,
            bsfc_pkg::ST_VSAT, bsfc_pkg::ST_DKEY:
            begin
                cmd.step_inc = !stat.step_last;
                cmd.step_clr = stat.step_last;
            end
            bsfc_pkg::ST_DCMP:
                cmd.dist_rej = stat.dist_over;
            bsfc_pkg::ST_OUT:
                cmd.out_set = !out_valid || out_ready;
            default:
                cmd.step_clr = 1'b0;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bsfc_pkg::ST_IDLE) |-> !in_ready)
        else $error("ready outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_set |=> out_valid)
        else $error("result not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bsfc_pkg::ST_DCMP && stat.dist_over) |=>
        (state_reg == bsfc_pkg::ST_OUT))
        else $error("distance reject lost");

endmodule
`default_nettype wire

>>> hw/rtl/bsfc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module bsfc_dp #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bsfc_pkg::cmd_t     cmd,
    output bsfc_pkg::stat_t         stat,
    input  wire logic               op,
    input  wire logic [3:0]         elem_index,
    input  wire logic signed [31:0] elem_value,
    input  wire logic signed [31:0] min_x,
    input  wire logic signed [31:0] min_y,
    input  wire logic signed [31:0] min_z,
    input  wire logic signed [31:0] max_x,
    input  wire logic signed [31:0] max_y,
    input  wire logic signed [31:0] max_z,
    input  wire logic [31:0]        tan_half_angle,
    input  wire logic [63:0]        dist_reject_sq,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic                    visible,
    output logic [2:0]              reject_cause,
    output logic [63:0]             dist_key,
    output logic [31:0]             sphere_radius,
    output logic signed [31:0]      view_x,
    output logic signed [31:0]      view_y,
    output logic signed [31:0]      view_z
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic signed [31:0] m_reg [12];
    logic signed [31:0] c_reg [3];
    logic [32:0]        d_reg [3];
    logic [3:0]         step_reg;
    logic [65:0]        acc_reg;
    logic signed [65:0] sacc_reg;
    logic signed [31:0] v_reg [3];
    logic [63:0]        rem_reg, root_reg, bit_reg, dkey_reg;
    logic [31:0]        rad_reg;
    logic signed [65:0] r2_reg, edge_reg;
    logic [2:0]         cause_reg;
    logic               ov_reg;

    // shared multiplier, one 33x33 signed product per cycle
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [1:0]         ax, rw;

    assign ax = step_reg[1:0];
    assign rw = step_reg[3:2];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.phase)
            bsfc_pkg::ST_DIST:
            begin
                mul_a = 33'(m_reg[9 + ax]);
                mul_b = 33'(m_reg[9 + ax]);
            end
            bsfc_pkg::ST_RAD:
            begin
                mul_a = $signed(d_reg[ax]);
                mul_b = $signed(d_reg[ax]);
            end
            bsfc_pkg::ST_XFORM:
            begin
                mul_a = 33'(c_reg[ax]);
                mul_b = 33'(m_reg[4'(ax) * 4'd3 + 4'(rw)]);
            end
            bsfc_pkg::ST_DKEY:
            begin
                mul_a = 33'(v_reg[ax]);
                mul_b = 33'(v_reg[ax]);
            end
            bsfc_pkg::ST_R2:
            begin
                mul_a = $signed({1'b0, rad_reg});
                mul_b = $signed({1'b0, bsfc_pkg::ROOT2_Q30});
            end
            bsfc_pkg::ST_EDGE:
            begin
                mul_a = -33'(v_reg[2]);
                mul_b = $signed({1'b0, tan_half_angle});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    logic last;
    always_comb
    begin
        case (cmd.phase)
            bsfc_pkg::ST_XFORM: last = (ax == 2'd2) && (rw == 2'd2);
            bsfc_pkg::ST_VSAT:  last = 1'b1;
            default:            last = (ax == 2'd2);
        endcase
    end

    assign stat.step_last = last;
    assign stat.dist_over = acc_reg[63:0] > dist_reject_sq || acc_reg[65:64] != 2'd0;
    assign stat.sqrt_done = (bit_reg == 64'd0);

    logic signed [65:0] sh;
    logic signed [65:0] xs, ys, rr;
    logic [63:0]        trial;
    assign sh = prod >>> FRAC_BITS;
    assign trial = root_reg + bit_reg;
    assign xs = 66'(v_reg[0]) <<< FRAC_BITS;
    assign ys = 66'(v_reg[1]) <<< FRAC_BITS;
    assign rr = r2_reg;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 12; i++)
                m_reg[i] <= (i == 0 || i == 4 || i == 8) ? ONE : 32'sd0;
            step_reg  <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cmd.capture && op == bsfc_pkg::OP_LOAD && elem_index < 4'd12)
                m_reg[elem_index] <= elem_value;
            if (cmd.step_clr)
                step_reg <= '0;
            else if (cmd.step_inc)
                step_reg <= (cmd.phase == bsfc_pkg::ST_XFORM && ax == 2'd2)
                            ? {rw + 2'd1, 2'd0} : step_reg + 4'd1;
            if (cmd.out_set)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            c_reg[0] <= 32'((34'(min_x) + 34'(max_x)) >>> 1);
            c_reg[1] <= 32'((34'(min_y) + 34'(max_y)) >>> 1);
            c_reg[2] <= 32'((34'(min_z) + 34'(max_z)) >>> 1);
            d_reg[0] <= (max_x >= min_x) ? 33'(34'(max_x) - 34'(min_x))
                                         : 33'(34'(min_x) - 34'(max_x));
            d_reg[1] <= (max_y >= min_y) ? 33'(34'(max_y) - 34'(min_y))
                                         : 33'(34'(min_y) - 34'(max_y));
            d_reg[2] <= (max_z >= min_z) ? 33'(34'(max_z) - 34'(min_z))
                                         : 33'(34'(min_z) - 34'(max_z));
            acc_reg  <= '0;
            sacc_reg <= '0;
            ov_reg   <= 1'b0;
        end
        case (cmd.phase)
            bsfc_pkg::ST_DIST:
                acc_reg <= acc_reg + 66'(prod);
            bsfc_pkg::ST_DCMP:
                acc_reg <= '0;
            bsfc_pkg::ST_RAD:
            begin
                acc_reg <= acc_reg + 66'(prod[65:2]);
                if (last)
                begin
                    rem_reg  <= 64'(acc_reg + 66'(prod[65:2]));
                    root_reg <= '0;
                    bit_reg  <= 64'd1 << 62;
                end
            end
            bsfc_pkg::ST_SQRT:
            begin
                // one result bit per cycle, restoring form
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
                if (bit_reg == 64'd0)
                    rad_reg <= root_reg[31:0];
            end
            bsfc_pkg::ST_XFORM:
            begin
                if (ax == 2'd2)
                begin
                    v_reg[rw] <= sat32(sacc_reg + sh + 66'(m_reg[9 + rw]));
                    sacc_reg <= '0;
                end
                else
                    sacc_reg <= sacc_reg + sh;
            end
            bsfc_pkg::ST_VSAT:
                acc_reg <= '0;
            bsfc_pkg::ST_DKEY:
            begin
                acc_reg <= acc_reg + 66'(prod);
                if (last)
                    dkey_reg <= 64'(acc_reg + 66'(prod));
            end
            bsfc_pkg::ST_R2:
                r2_reg <= 66'(prod >>> 30) <<< FRAC_BITS;
            bsfc_pkg::ST_EDGE:
                edge_reg <= prod;
            bsfc_pkg::ST_TEST:
            begin
                if (xs + rr < edge_reg)       cause_reg <= bsfc_pkg::CAUSE_LEFT;
                else if (xs - rr > -edge_reg) cause_reg <= bsfc_pkg::CAUSE_RIGHT;
                else if (ys - rr > -edge_reg) cause_reg <= bsfc_pkg::CAUSE_TOP;
                else if (ys + rr < edge_reg)  cause_reg <= bsfc_pkg::CAUSE_BOTTOM;
                else                          cause_reg <= bsfc_pkg::CAUSE_NONE;
            end
            default:
                ;
        endcase
        if (cmd.dist_rej)
            ov_reg <= 1'b1;
        if (cmd.out_set)
        begin
            visible       <= !ov_reg && cause_reg == bsfc_pkg::CAUSE_NONE && !cmd.dist_rej;
            reject_cause  <= ov_reg ? bsfc_pkg::CAUSE_DIST : cause_reg;
            dist_key      <= ov_reg ? 64'd0 : dkey_reg;
            sphere_radius <= ov_reg ? 32'd0 : rad_reg;
            view_x        <= ov_reg ? 32'sd0 : v_reg[0];
            view_y        <= ov_reg ? 32'sd0 : v_reg[1];
            view_z        <= ov_reg ? 32'sd0 : v_reg[2];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !visible) |-> (reject_cause != bsfc_pkg::CAUSE_NONE))
        else $error("hidden without cause");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reject_cause == bsfc_pkg::CAUSE_DIST) |-> (dist_key == 64'd0))
        else $error("reject carries distance");

endmodule
`default_nettype wire

>>> hw/rtl/bounding_sphere_frustum_cull_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | signals                              | beat
// in      | in_valid/in_ready, op..max_z          | one load or one mesh box
// out     | out_valid/out_ready, visible..view_z  | one cull result per mesh
// cfg     | psel/penable/pwrite/paddr/pwdata      | APB register write/read
// A mesh result is computed by the single shared 33x33 multiplier
// (3+9+3+2 products, plus 3 with the distance limit on) and the
// bit-serial square root. A distance reject goes from the distance
// compare straight to output. Input is ready again in the same cycle
// that the result appears. Reset restores an identity transform.
// The result register frees the datapath; a stalled output holds the
// next mesh in its final state until the result is taken.
module bounding_sphere_frustum_cull_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               op,
    input  wire logic [3:0]         elem_index,
    input  wire logic signed [31:0] elem_value,
    input  wire logic signed [31:0] min_x,
    input  wire logic signed [31:0] min_y,
    input  wire logic signed [31:0] min_z,
    input  wire logic signed [31:0] max_x,
    input  wire logic signed [31:0] max_y,
    input  wire logic signed [31:0] max_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    visible,
    output logic [2:0]              reject_cause,
    output logic [63:0]             dist_key,
    output logic [31:0]             sphere_radius,
    output logic signed [31:0]      view_x,
    output logic signed [31:0]      view_y,
    output logic signed [31:0]      view_z,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);

    logic [31:0] tan_reg;
    logic [63:0] dist_reg;
    bsfc_pkg::cmd_t  cmd;
    bsfc_pkg::stat_t stat;
    logic [0:0] ridx;

    assign pready = 1'b1;
    assign ridx = paddr[3];

    // registers at 8-byte spacing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tan_reg  <= bsfc_pkg::TAN_RESET;
            dist_reg <= 64'd0;
        end
        else if (psel && penable && pwrite)
        begin
            if (ridx == bsfc_pkg::REG_TAN)
                tan_reg <= pwdata[31:0];
            else
                dist_reg <= pwdata;
        end
    end

    always_comb
    begin
        case (ridx)
            bsfc_pkg::REG_TAN: prdata = {32'd0, tan_reg};
            default:           prdata = dist_reg;
        endcase
    end

    bsfc_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .op             (op),
        .in_ready       (in_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .dist_reject_sq (dist_reg),
        .stat           (stat),
        .cmd            (cmd)
    );

    bsfc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .op             (op),
        .elem_index     (elem_index),
        .elem_value     (elem_value),
        .min_x          (min_x),
        .min_y          (min_y),
        .min_z          (min_z),
        .max_x          (max_x),
        .max_y          (max_y),
        .max_z          (max_z),
        .tan_half_angle (tan_reg),
        .dist_reject_sq (dist_reg),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .visible        (visible),
        .reject_cause   (reject_cause),
        .dist_key       (dist_key),
        .sphere_radius  (sphere_radius),
        .view_x         (view_x),
        .view_y         (view_y),
        .view_z         (view_z)
    );

endmodule
`default_nettype wire
